// ----- sv/pira_pkg.sv -----
// Shared types for the per-id runtime accumulator.
// Used by pira_cell and per_id_runtime_accumulator; no dependencies.
package pira_pkg;

    localparam int unsigned PID_W  = 22;
    localparam int unsigned TIME_W = 64;

    localparam logic OP_CHARGE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Item broadcast to every cell of the row
    typedef struct packed {
        logic              op;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] running_us;
    } t_req;

    // Cell controls for the current pass
    typedef struct packed {
        logic look;  // match / first-free evaluation
        logic upd;   // write back the selected cell
    } t_ctl;

    // Result handed from cell to cell along the row
    typedef struct packed {
        logic [TIME_W-1:0] total_us;
        logic              hit;
    } t_res;

endpackage

// ----- sv/pira_cell.sv -----
// One table entry of the accumulator row: id, valid mark, total, baseline.
// Depends on pira_pkg (t_req, t_ctl, t_res).
module pira_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pira_pkg::t_ctl i_ctl,
    input  pira_pkg::t_req i_req,
    input  logic           i_prev_valid,
    output logic           o_valid,
    input  logic           i_prev_found,
    output logic           o_found,
    input  pira_pkg::t_res i_res,
    output pira_pkg::t_res o_res
);

    logic                        r_valid;
    logic [pira_pkg::PID_W-1:0]  r_id;
    logic [pira_pkg::TIME_W-1:0] r_total;
    logic [pira_pkg::TIME_W-1:0] r_baseline;
    logic                        r_hit;
    logic                        r_new;

    logic n_match;
    logic n_claim;
    logic is_charge;

    assign is_charge = (i_req.op == pira_pkg::OP_CHARGE);
    assign n_match   = r_valid && (r_id == i_req.pid);
    // Used cells always precede free ones, so the first free cell is the
    // free one whose left neighbor is in use, and any match lies to its left.
    assign n_claim   = !r_valid && i_prev_valid && !i_prev_found && is_charge &&
                       (i_req.pid != '0);
    assign o_found   = i_prev_found || n_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_new   <= 1'b0;
        end else begin
            if (i_ctl.look) begin
                r_hit <= n_match;
                r_new <= n_claim;
            end
            if (i_ctl.upd && is_charge) begin
                if (r_new) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && is_charge) begin
            if (r_new) begin
                r_id       <= i_req.pid;
                r_total    <= '0;
                r_baseline <= i_req.running_us;
            end else if (r_hit) begin
                // a drop below the baseline is a restart: nothing added
                if (i_req.running_us >= r_baseline) begin
                    r_total <= r_total + (i_req.running_us - r_baseline);
                end
                r_baseline <= i_req.running_us;
            end
        end
    end

    assign o_valid = r_valid;

    always_comb begin
        o_res = i_res;
        if (r_hit || r_new) begin
            o_res.total_us = i_res.total_us | r_total;
            o_res.hit      = 1'b1;
        end
    end

endmodule

// ----- sv/per_id_runtime_accumulator.sv -----
// Top level of the per-id runtime accumulator: sequencer, row of cells,
// output register. Depends on pira_pkg and pira_cell.
//
// Input channel i_valid/o_ready carries one beat per item: i_op (0 charge,
// 1 query), i_pid and i_running_us. Output channel o_valid/i_ready carries
// o_total_us and o_hit, exactly one result beat per input beat, in order.
// A charge finds the cell holding the id or claims the first free cell,
// adds the non-negative runtime delta and returns the new total; a query
// only reads. Id 0, a charge to a full table or a query for an absent id give total 0, hit 0.
// An item passes through accept, a lookup pass over the cell row (match
// and first-free marks), an update pass in the selected cell, and the
// readout along the row into the output register. A new item is accepted
// only after the previous one has been loaded into the output register.
// The output register frees the input side: a new beat is accepted while
// a result waits. If the receiver stalls with a result still held, the
// next item waits in its readout step until the register frees.
// Reset (synchronous, active low) empties every cell and drops any result.
module per_id_runtime_accumulator #(
    parameter int unsigned ENTRIES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [pira_pkg::PID_W-1:0]  i_pid,
    input  logic [pira_pkg::TIME_W-1:0] i_running_us,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pira_pkg::TIME_W-1:0] o_total_us,
    output logic                        o_hit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    pira_pkg::t_req              r_req;
    logic                        r_out_valid;
    logic [pira_pkg::TIME_W-1:0] r_total;
    logic                        r_hit;

    pira_pkg::t_ctl ctl;
    pira_pkg::t_res res_chain [ENTRIES+1];
    logic           valid_chain [ENTRIES+1];
    logic           found_chain [ENTRIES+1];
    logic           out_load;

    assign o_ready  = (r_state == ST_IDLE);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_LOOK;
            ST_LOOK: n_state = ST_UPD;
            ST_UPD:  n_state = ST_OUT;
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign ctl.look = (r_state == ST_LOOK);
    assign ctl.upd  = (r_state == ST_UPD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req.op         <= i_op;
            r_req.pid        <= i_pid;
            r_req.running_us <= i_running_us;
        end
        if (out_load) begin
            r_total <= res_chain[ENTRIES].total_us;
            r_hit   <= res_chain[ENTRIES].hit;
        end
    end

    assign res_chain[0]   = '0;
    assign valid_chain[0] = 1'b1;
    assign found_chain[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        pira_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_req        (r_req),
            .i_prev_valid (valid_chain[g]),
            .o_valid      (valid_chain[g+1]),
            .i_prev_found (found_chain[g]),
            .o_found      (found_chain[g+1]),
            .i_res        (res_chain[g]),
            .o_res        (res_chain[g+1])
        );
    end

    assign o_valid    = r_out_valid;
    assign o_total_us = r_total;
    assign o_hit      = r_hit;

endmodule

// ----- verif/per_id_runtime_accumulator_tb.sv -----
// Testbench for per_id_runtime_accumulator: directed and random charge/query beats
// checked against a scoreboard that keeps its own per-id runtime table.
// Depends on pira_pkg and the per_id_runtime_accumulator RTL.
`timescale 1ns / 1ps

module per_id_runtime_accumulator_tb;

    localparam int ENTRIES = 32;
    localparam int POOL    = 40;  // more ids than cells, so the table fills up
    localparam int N_RAND  = 1400;

    typedef struct {
        logic [pira_pkg::TIME_W-1:0] total_us;
        logic                        hit;
    } t_runtime_result;

    // Shadow of the runtime table plus the queue of totals still to come back
    class t_runtime_ledger;
        bit                          cell_used  [ENTRIES];
        logic [pira_pkg::PID_W-1:0]  cell_pid   [ENTRIES];
        logic [pira_pkg::TIME_W-1:0] cell_total [ENTRIES];
        logic [pira_pkg::TIME_W-1:0] cell_base  [ENTRIES];
        t_runtime_result             pending_totals[$];
        int errors;
        int n_charge, n_query, n_hit, n_restart, n_full;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                cell_used[i]  = 0;
                cell_pid[i]   = '0;
                cell_total[i] = '0;
                cell_base[i]  = '0;
            end
            errors = 0;
            n_charge = 0; n_query = 0; n_hit = 0; n_restart = 0; n_full = 0;
        endfunction

        // Apply one accepted beat to the shadow table, queue its result
        function void record_item(logic op, logic [pira_pkg::PID_W-1:0] pid,
                                  logic [pira_pkg::TIME_W-1:0] rd);
            int slot;
            int free_cell;
            t_runtime_result res;
            slot = -1;
            free_cell = -1;
            res.total_us = '0;
            res.hit = 1'b0;
            if (op == pira_pkg::OP_CHARGE) n_charge++;
            else n_query++;
            if (pid != '0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && cell_used[i] && cell_pid[i] == pid) slot = i;
                    if (free_cell < 0 && !cell_used[i]) free_cell = i;
                end
                if (op == pira_pkg::OP_CHARGE) begin
                    if (slot < 0 && free_cell >= 0) begin
                        slot = free_cell;
                        cell_used[slot]  = 1;
                        cell_pid[slot]   = pid;
                        cell_total[slot] = '0;
                        cell_base[slot]  = rd;
                    end else if (slot < 0) begin
                        n_full++;
                    end
                    if (slot >= 0) begin
                        if (rd >= cell_base[slot]) cell_total[slot] += rd - cell_base[slot];
                        else n_restart++;
                        cell_base[slot] = rd;
                        res.total_us = cell_total[slot];
                        res.hit = 1'b1;
                    end
                end else if (slot >= 0) begin
                    res.total_us = cell_total[slot];
                    res.hit = 1'b1;
                end
            end
            if (res.hit) n_hit++;
            pending_totals.push_back(res);
        endfunction

        function void compare_result(logic [pira_pkg::TIME_W-1:0] total_us, logic hit);
            t_runtime_result exp_res;
            if (pending_totals.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result beat with nothing pending: total_us=%h hit=%b",
                             total_us, hit);
                return;
            end
            exp_res = pending_totals.pop_front();
            if (total_us !== exp_res.total_us || hit !== exp_res.hit) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: total_us exp %h got %h, hit exp %b got %b",
                             exp_res.total_us, total_us, exp_res.hit, hit);
            end
        endfunction

        function int pending_count();
            return pending_totals.size();
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic                        i_op = pira_pkg::OP_CHARGE;
    logic [pira_pkg::PID_W-1:0]  i_pid = '0;
    logic [pira_pkg::TIME_W-1:0] i_running_us = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [pira_pkg::TIME_W-1:0] o_total_us;
    logic                        o_hit;

    t_runtime_ledger ledger = new();
    bit idle_on = 1'b1;

    logic [pira_pkg::PID_W-1:0]  pool_pid  [POOL];
    logic [pira_pkg::TIME_W-1:0] pool_last [POOL];

    per_id_runtime_accumulator #(.ENTRIES(ENTRIES)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_pid        (i_pid),
        .i_running_us (i_running_us),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_total_us   (o_total_us),
        .o_hit        (o_hit)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // Called right after a rising edge; returns at the edge that takes the beat
    task automatic drive_item(input logic op, input logic [pira_pkg::PID_W-1:0] pid,
                              input logic [pira_pkg::TIME_W-1:0] rd);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_pid        <= pid;
        i_running_us <= rd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        ledger.record_item(op, pid, rd);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (ledger.pending_count() != 0) @(posedge i_clk);
    endtask

    // Result side: random stall bursts while idling is on
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) ledger.compare_result(o_total_us, o_hit);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 99) < 15) begin
                i_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int sel;
        int idx;
        bit dup;
        logic [pira_pkg::PID_W-1:0]  cand;
        logic                        op;
        logic [pira_pkg::TIME_W-1:0] rd;

        for (int i = 0; i < POOL; i++) begin
            do begin
                cand = 22'($urandom_range(3, 22'h3FFFFE));
                dup = 0;
                for (int j = 0; j < i; j++) if (pool_pid[j] == cand) dup = 1;
            end while (dup);
            pool_pid[i]  = cand;
            pool_last[i] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reserved id, absent query, wrap, restart, field extremes
        drive_item(pira_pkg::OP_QUERY,  '0, '0);
        drive_item(pira_pkg::OP_CHARGE, '0, '1);
        drive_item(pira_pkg::OP_QUERY,  22'd1, '0);
        drive_item(pira_pkg::OP_CHARGE, 22'd1, '0);
        drive_item(pira_pkg::OP_CHARGE, 22'd1, '1);
        drive_item(pira_pkg::OP_CHARGE, 22'd1, '0);              // drop: total unchanged
        drive_item(pira_pkg::OP_CHARGE, 22'd1, 64'd1);           // total wraps to 0
        drive_item(pira_pkg::OP_QUERY,  22'd1, '1);
        drive_item(pira_pkg::OP_CHARGE, '1, 64'h8000_0000_0000_0000);
        drive_item(pira_pkg::OP_CHARGE, '1, 64'h8000_0000_0000_0001);
        drive_item(pira_pkg::OP_CHARGE, '1, 64'h7FFF_FFFF_FFFF_FFFF);
        drive_item(pira_pkg::OP_CHARGE, '1, 64'h7FFF_FFFF_FFFF_FFFF);
        drive_item(pira_pkg::OP_QUERY,  '1, '1);
        drive_item(pira_pkg::OP_QUERY,  '0, {$urandom, $urandom});
        drive_item(pira_pkg::OP_CHARGE, 22'd2, 64'h5555_5555_5555_5555);
        drive_item(pira_pkg::OP_CHARGE, 22'd2, 64'hAAAA_AAAA_AAAA_AAAA);
        drive_item(pira_pkg::OP_QUERY,  22'd2, '0);
        drain_results();

        // Claim cells for the pool until the table is full; the tail gets hit 0
        for (int i = 0; i < POOL; i++) begin
            rd = {$urandom, $urandom} >> $urandom_range(0, 63);
            pool_last[i] = rd;
            drive_item(pira_pkg::OP_CHARGE, pool_pid[i], rd);
        end
        drain_results();

        for (int n = 0; n < N_RAND; n++) begin
            if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (n >= N_RAND - 200) idle_on = 1'b0;
            if (n == N_RAND / 2) drain_results();
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                op = ($urandom_range(0, 1) == 0) ? pira_pkg::OP_CHARGE : pira_pkg::OP_QUERY;
                drive_item(op, '0, {$urandom, $urandom});
            end else if (sel < 8) begin
                op = ($urandom_range(0, 1) == 0) ? pira_pkg::OP_CHARGE : pira_pkg::OP_QUERY;
                drive_item(op, 22'($urandom_range(0, 22'h3FFFFF)), {$urandom, $urandom});
            end else begin
                idx = $urandom_range(0, POOL - 1);
                if ($urandom_range(0, 99) < 20) begin
                    drive_item(pira_pkg::OP_QUERY, pool_pid[idx], {$urandom, $urandom});
                end else begin
                    sel = $urandom_range(0, 99);
                    if (sel < 70) rd = pool_last[idx] + 64'($urandom_range(0, 5000));
                    else if (sel < 80) rd = pool_last[idx] - 64'($urandom_range(1, 1000));
                    else if (sel < 90) rd = {$urandom, $urandom};
                    else rd = pool_last[idx] + ({$urandom, $urandom} >> $urandom_range(0, 8));
                    pool_last[idx] = rd;
                    drive_item(pira_pkg::OP_CHARGE, pool_pid[idx], rd);
                end
            end
        end
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d charges and %0d queries: %0d hits, %0d restarts,",
                 ledger.n_charge, ledger.n_query, ledger.n_hit, ledger.n_restart);
        $display("%0d charges turned away by a full table, %0d mismatches",
                 ledger.n_full, ledger.errors);
        if (ledger.errors == 0 && ledger.pending_count() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
